@@ hdl/lgce_pkg.sv @@
// shared constants, codes and controller/datapath interface types
package lgce_pkg;

  // field widths
  localparam int COORD_W   = 24;
  localparam int COLOUR_W  = 32;
  localparam int OFF_W     = 16;
  localparam int SLOT_W    = 3;
  localparam int COUNT_W   = 4;
  localparam int MODE_W    = 2;
  localparam int CH_W      = 8;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  // default table depth and counter width covering its whole range
  localparam int MAX_STOPS_DEFAULT = 8;
  localparam int CNT_W             = 6;

  // sequencing lengths
  localparam int MUL_STEPS = 4;
  localparam int DIV_BITS  = 16;
  localparam int Q_BITS    = 8;

  // brush modes
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOLID = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GRAD  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNSUP = 2'd3;

  // register indexes
  localparam logic [2:0] REG_BRUSH_MODE   = 3'd0;
  localparam logic [2:0] REG_AXIS_START_X = 3'd1;
  localparam logic [2:0] REG_AXIS_START_Y = 3'd2;
  localparam logic [2:0] REG_AXIS_END_X   = 3'd3;
  localparam logic [2:0] REG_AXIS_END_Y   = 3'd4;
  localparam logic [2:0] REG_FIRST_COLOUR = 3'd5;
  localparam logic [2:0] REG_LAST_COLOUR  = 3'd6;
  localparam logic [2:0] REG_STOP_COUNT   = 3'd7;

  // shared multiplier operand selection
  localparam logic [1:0] MUL_DXDX = 2'd0;
  localparam logic [1:0] MUL_DYDY = 2'd1;
  localparam logic [1:0] MUL_PXDX = 2'd2;
  localparam logic [1:0] MUL_PYDY = 2'd3;

  // result colour source
  localparam logic [2:0] RES_ZERO  = 3'd0;
  localparam logic [2:0] RES_FIRST = 3'd1;
  localparam logic [2:0] RES_LAST  = 3'd2;
  localparam logic [2:0] RES_BLACK = 3'd3;
  localparam logic [2:0] RES_BLEND = 3'd4;

  localparam logic [COLOUR_W-1:0] OPAQUE_BLACK = 32'h0000_00FF;

  typedef struct packed {
    logic             stop_wr;
    logic             load;
    logic             mul_en;
    logic [1:0]       mul_sel;
    logic             acc_en;
    logic             chk_init;
    logic             div_step;
    logic             walk_step;
    logic             blend_mul;
    logic             bdiv_step;
    logic             out_load;
    logic [2:0]       res_sel;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic len2_zero;
    logic dot_le0;
    logic dot_ge;
    logic walk_end;
    logic out_free;
  } stat_t;

endpackage

@@ hdl/linear_gradient_colour_evaluator.sv @@
// top level: register file, controller and datapath of the gradient colour evaluator
//
// Usage
//   Input channel (in_valid/in_stall) carries one item: kind 0 asks for the
//   brush colour at (point_x, point_y), kind 1 writes stop table entry
//   stop_slot with stop_position and stop_colour and gives no result.
//   Output channel (out_valid/out_stall) returns red, green, blue, alpha.
//   The user must write registers through the APB port only while the block is idle; the block does not enforce this.
// Sequence
//   A stop write is done on acceptance and the block stays idle. A colour item for a
//   no-brush, solid or unsupported brush goes from idle to the done state,
//   which loads the result once the output register is free; the next item
//   is taken back in idle. A linear gradient runs the products on the shared
//   25x25 multiplier, the end checks, the one-bit-a-cycle division giving t,
//   the stop walk, the channel interpolation divide and the result load,
//   then returns to idle. Early outs (t at or outside the ends) go from the
//   end checks to the result load. One item is worked on at a time; in_stall
//   is high while it is.
// Reset
//   Synchronous: configuration and control registers, the stop table and out_valid clear; no result is held.
// Stalls
//   The result waits in the output register; a new item is still taken
//   meanwhile and waits for the register to empty before it completes.
module linear_gradient_colour_evaluator #(
  parameter int MAX_STOPS = lgce_pkg::MAX_STOPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic signed [lgce_pkg::COORD_W-1:0] point_x,
  input  logic signed [lgce_pkg::COORD_W-1:0] point_y,
  input  logic [lgce_pkg::SLOT_W-1:0]         stop_slot,
  input  logic [lgce_pkg::OFF_W-1:0]          stop_position,
  input  logic [lgce_pkg::COLOUR_W-1:0]       stop_colour,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lgce_pkg::CH_W-1:0]           red,
  output logic [lgce_pkg::CH_W-1:0]           green,
  output logic [lgce_pkg::CH_W-1:0]           blue,
  output logic [lgce_pkg::CH_W-1:0]           alpha,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lgce_pkg::PADDR_W-1:0]        paddr,
  input  logic [lgce_pkg::PDATA_W-1:0]        pwdata,
  output logic [lgce_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int CRD_W = lgce_pkg::COORD_W;
  localparam int DW    = lgce_pkg::PDATA_W;

  logic [lgce_pkg::MODE_W-1:0]  brush_mode;
  logic signed [CRD_W-1:0]      axis_start_x, axis_start_y, axis_end_x, axis_end_y;
  logic [lgce_pkg::COLOUR_W-1:0] first_colour, last_colour, out_colour;
  logic [lgce_pkg::COUNT_W-1:0] stop_count;
  logic [2:0]                   reg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brush_mode   <= lgce_pkg::MODE_NONE;
      axis_start_x <= '0;
      axis_start_y <= '0;
      axis_end_x   <= '0;
      axis_end_y   <= '0;
      first_colour <= '0;
      last_colour  <= '0;
      stop_count   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lgce_pkg::REG_BRUSH_MODE:   brush_mode   <= pwdata[lgce_pkg::MODE_W-1:0];
        lgce_pkg::REG_AXIS_START_X: axis_start_x <= pwdata[CRD_W-1:0];
        lgce_pkg::REG_AXIS_START_Y: axis_start_y <= pwdata[CRD_W-1:0];
        lgce_pkg::REG_AXIS_END_X:   axis_end_x   <= pwdata[CRD_W-1:0];
        lgce_pkg::REG_AXIS_END_Y:   axis_end_y   <= pwdata[CRD_W-1:0];
        lgce_pkg::REG_FIRST_COLOUR: first_colour <= pwdata;
        lgce_pkg::REG_LAST_COLOUR:  last_colour  <= pwdata;
        default:                    stop_count   <= pwdata[lgce_pkg::COUNT_W-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      lgce_pkg::REG_BRUSH_MODE:   prdata = DW'(brush_mode);
      lgce_pkg::REG_AXIS_START_X: prdata = DW'(axis_start_x);
      lgce_pkg::REG_AXIS_START_Y: prdata = DW'(axis_start_y);
      lgce_pkg::REG_AXIS_END_X:   prdata = DW'(axis_end_x);
      lgce_pkg::REG_AXIS_END_Y:   prdata = DW'(axis_end_y);
      lgce_pkg::REG_FIRST_COLOUR: prdata = first_colour;
      lgce_pkg::REG_LAST_COLOUR:  prdata = last_colour;
      default:                    prdata = DW'(stop_count);
    endcase
  end

  lgce_pkg::cmd_t  cmd;
  lgce_pkg::stat_t stat;

  // sequencing
  lgce_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .kind       (kind),
    .brush_mode (brush_mode),
    .stat       (stat),
    .cmd        (cmd),
    .in_stall   (in_stall)
  );

  // arithmetic and stop table
  lgce_dpath #(
    .MAX_STOPS (MAX_STOPS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .axis_start_x  (axis_start_x),
    .axis_start_y  (axis_start_y),
    .axis_end_x    (axis_end_x),
    .axis_end_y    (axis_end_y),
    .first_colour  (first_colour),
    .last_colour   (last_colour),
    .stop_count    (stop_count),
    .point_x       (point_x),
    .point_y       (point_y),
    .stop_slot     (stop_slot),
    .stop_position (stop_position),
    .stop_colour   (stop_colour),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_colour    (out_colour)
  );

  // channel split
  assign red   = out_colour[31:24];
  assign green = out_colour[23:16];
  assign blue  = out_colour[15:8];
  assign alpha = out_colour[7:0];

endmodule

@@ hdl/lgce_ctrl.sv @@
// sequencing state machine for the colour evaluator
module lgce_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        kind,
  input  logic [lgce_pkg::MODE_W-1:0] brush_mode,
  input  lgce_pkg::stat_t             stat,
  output lgce_pkg::cmd_t              cmd,
  output logic                        in_stall
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_BMUL = 3'd5;
  localparam logic [2:0] S_BDIV = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam int CW = lgce_pkg::CNT_W;

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [2:0]    res_sel, res_sel_next;

  // state, step counter and result source
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      res_sel <= lgce_pkg::RES_ZERO;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      res_sel <= res_sel_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    res_sel_next = res_sel;
    cmd          = '0;
    cmd.idx      = cnt;
    cmd.res_sel  = res_sel;
    cmd.mul_sel  = cnt[1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind) begin
            cmd.stop_wr = 1'b1;
          end else begin
            cmd.load = 1'b1;
            unique case (brush_mode)
              lgce_pkg::MODE_NONE: begin
                res_sel_next = lgce_pkg::RES_ZERO;
                state_next   = S_DONE;
              end
              lgce_pkg::MODE_SOLID: begin
                res_sel_next = lgce_pkg::RES_FIRST;
                state_next   = S_DONE;
              end
              lgce_pkg::MODE_GRAD: begin
                cnt_next   = '0;
                state_next = S_MUL;
              end
              default: begin
                res_sel_next = lgce_pkg::RES_BLACK;
                state_next   = S_DONE;
              end
            endcase
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = (cnt < CW'(lgce_pkg::MUL_STEPS));
        cmd.acc_en = (cnt != '0);
        cnt_next   = cnt + CW'(1);
        if (cnt == CW'(lgce_pkg::MUL_STEPS)) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        priority if (stat.len2_zero || stat.dot_le0) begin
          res_sel_next = lgce_pkg::RES_FIRST;
          state_next   = S_DONE;
        end else if (stat.dot_ge) begin
          res_sel_next = lgce_pkg::RES_LAST;
          state_next   = S_DONE;
        end else begin
          cmd.chk_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CW'(1);
        if (cnt == CW'(lgce_pkg::DIV_BITS - 1)) begin
          cnt_next   = '0;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_end) begin
          state_next = S_BMUL;
        end else begin
          cmd.walk_step = 1'b1;
          cnt_next      = cnt + CW'(1);
        end
      end
      S_BMUL: begin
        cmd.blend_mul = 1'b1;
        cnt_next      = '0;
        state_next    = S_BDIV;
      end
      S_BDIV: begin
        cmd.bdiv_step = 1'b1;
        cnt_next      = cnt + CW'(1);
        if (cnt == CW'(lgce_pkg::Q_BITS - 1)) begin
          res_sel_next = lgce_pkg::RES_BLEND;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // product sequencing never runs past its last accumulate
  a_mul_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (cnt <= CW'(lgce_pkg::MUL_STEPS)))
    else $error("multiply step counter overran");

  // an interpolation always finishes with the blended colour selected
  a_blend_sel: assert property (@(posedge clk) disable iff (rst)
    (state == S_BDIV && cnt == CW'(lgce_pkg::Q_BITS - 1)) |=>
      (state == S_DONE && res_sel == lgce_pkg::RES_BLEND))
    else $error("blend finished without blend result");

  // the division always runs exactly its full bit count before the walk
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && $past(state) == S_DIV) |->
      ($past(cnt) == CW'(lgce_pkg::DIV_BITS - 1)))
    else $error("division left early");

endmodule

@@ hdl/lgce_dpath.sv @@
// projection, division, stop walk and channel interpolation datapath
module lgce_dpath #(
  parameter int MAX_STOPS = lgce_pkg::MAX_STOPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lgce_pkg::cmd_t                      cmd,
  output lgce_pkg::stat_t                     stat,
  input  logic signed [lgce_pkg::COORD_W-1:0] axis_start_x,
  input  logic signed [lgce_pkg::COORD_W-1:0] axis_start_y,
  input  logic signed [lgce_pkg::COORD_W-1:0] axis_end_x,
  input  logic signed [lgce_pkg::COORD_W-1:0] axis_end_y,
  input  logic [lgce_pkg::COLOUR_W-1:0]       first_colour,
  input  logic [lgce_pkg::COLOUR_W-1:0]       last_colour,
  input  logic [lgce_pkg::COUNT_W-1:0]        stop_count,
  input  logic signed [lgce_pkg::COORD_W-1:0] point_x,
  input  logic signed [lgce_pkg::COORD_W-1:0] point_y,
  input  logic [lgce_pkg::SLOT_W-1:0]         stop_slot,
  input  logic [lgce_pkg::OFF_W-1:0]          stop_position,
  input  logic [lgce_pkg::COLOUR_W-1:0]       stop_colour,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [lgce_pkg::COLOUR_W-1:0]       out_colour
);

  localparam int CW     = lgce_pkg::CNT_W;
  localparam int IDX_W  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CRD_W  = lgce_pkg::COORD_W;
  localparam int DIF_W  = CRD_W + 1;
  localparam int PRD_W  = 2 * DIF_W;
  localparam int ACC_W  = PRD_W + 1;
  localparam int OW     = lgce_pkg::OFF_W;
  localparam int SPAN_W = OW + 1;
  localparam int NUM_W  = lgce_pkg::CH_W + SPAN_W + 1;
  localparam int CLW    = lgce_pkg::COLOUR_W;
  localparam int CHW    = lgce_pkg::CH_W;

  // stop table, cleared at reset
  logic [OW-1:0]  off_tab [MAX_STOPS];
  logic [CLW-1:0] col_tab [MAX_STOPS];
  logic [CW-1:0]  slot_ext;

  assign slot_ext = CW'(stop_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STOPS; i++) begin
        off_tab[i] <= '0;
        col_tab[i] <= '0;
      end
    end else if (cmd.stop_wr && (int'(stop_slot) < MAX_STOPS)) begin
      off_tab[slot_ext[IDX_W-1:0]] <= stop_position;
      col_tab[slot_ext[IDX_W-1:0]] <= stop_colour;
    end
  end

  // query point capture
  logic signed [CRD_W-1:0] px, py;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= point_x;
      py <= point_y;
    end
  end

  // axis and offset differences
  logic signed [DIF_W-1:0] dx, dy, qx, qy;

  assign dx = {axis_end_x[CRD_W-1], axis_end_x} - {axis_start_x[CRD_W-1], axis_start_x};
  assign dy = {axis_end_y[CRD_W-1], axis_end_y} - {axis_start_y[CRD_W-1], axis_start_y};
  assign qx = {px[CRD_W-1], px} - {axis_start_x[CRD_W-1], axis_start_x};
  assign qy = {py[CRD_W-1], py} - {axis_start_y[CRD_W-1], axis_start_y};

  // shared multiplier, product registered before accumulation
  logic signed [DIF_W-1:0] op_a, op_b;
  logic signed [PRD_W-1:0] prod;
  logic [1:0]              prod_sel;
  logic signed [ACC_W-1:0] len2, dot, prod_ext;

  always_comb begin
    unique case (cmd.mul_sel)
      lgce_pkg::MUL_DXDX: begin op_a = dx; op_b = dx; end
      lgce_pkg::MUL_DYDY: begin op_a = dy; op_b = dy; end
      lgce_pkg::MUL_PXDX: begin op_a = qx; op_b = dx; end
      default:            begin op_a = qy; op_b = dy; end
    endcase
  end

  assign prod_ext = {prod[PRD_W-1], prod};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= op_a * op_b;
      prod_sel <= cmd.mul_sel;
    end
    if (cmd.acc_en) begin
      unique case (prod_sel)
        lgce_pkg::MUL_DXDX: len2 <= prod_ext;
        lgce_pkg::MUL_DYDY: len2 <= len2 + prod_ext;
        lgce_pkg::MUL_PXDX: dot  <= prod_ext;
        default:            dot  <= dot + prod_ext;
      endcase
    end
  end

  assign stat.len2_zero = (len2 == '0);
  assign stat.dot_le0   = dot[ACC_W-1] || (dot == '0);
  assign stat.dot_ge    = (dot >= len2);

  // restoring division dot / len2, one quotient bit per step
  logic [ACC_W-1:0] rem;
  logic [ACC_W:0]   rem_sh, den_ext;
  logic [OW-1:0]    t16;

  assign rem_sh  = {rem, 1'b0};
  assign den_ext = {1'b0, len2};

  always_ff @(posedge clk) begin
    if (cmd.chk_init) begin
      rem <= dot;
      t16 <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= den_ext) begin
        rem <= ACC_W'(rem_sh - den_ext);
        t16 <= {t16[OW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[ACC_W-1:0];
        t16 <= {t16[OW-2:0], 1'b0};
      end
    end
  end

  // stop walk, one table entry per step
  logic [OW-1:0]     lo;
  logic [SPAN_W-1:0] hi;
  logic [CLW-1:0]    cl, ch;
  logic              found;
  logic [CW-1:0]     n_lim;
  logic [OW-1:0]     w_off;
  logic [CLW-1:0]    w_col;

  assign n_lim = (int'(stop_count) > MAX_STOPS) ? CW'(MAX_STOPS) : CW'(stop_count);
  assign w_off = off_tab[cmd.idx[IDX_W-1:0]];
  assign w_col = col_tab[cmd.idx[IDX_W-1:0]];
  assign stat.walk_end = found || (cmd.idx >= n_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.chk_init) begin
      found <= 1'b0;
    end else if (cmd.walk_step && (w_off > t16)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk_init) begin
      lo <= '0;
      hi <= SPAN_W'(1) << OW;
      cl <= first_colour;
      ch <= last_colour;
    end else if (cmd.walk_step) begin
      if (w_off <= t16) begin
        lo <= w_off;
        cl <= w_col;
      end else begin
        hi <= SPAN_W'(w_off);
        ch <= w_col;
      end
    end
  end

  // per-channel lanes: weighted sum then 8-step restoring division by span
  logic [SPAN_W-1:0] span, dpos, wlo;
  logic [NUM_W-1:0]  dvs;
  logic [NUM_W-1:0]  num [4];
  logic [CHW-1:0]    q   [4];

  assign span = hi - SPAN_W'(lo);
  assign dpos = SPAN_W'(t16) - SPAN_W'(lo);
  assign wlo  = span - dpos;

  always_ff @(posedge clk) begin
    if (cmd.blend_mul) begin
      dvs <= NUM_W'(span) << (lgce_pkg::Q_BITS - 1);
    end else if (cmd.bdiv_step) begin
      dvs <= dvs >> 1;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [CHW-1:0] a_ch, b_ch;

    assign a_ch = cl[CLW-1-CHW*k -: CHW];
    assign b_ch = ch[CLW-1-CHW*k -: CHW];

    always_ff @(posedge clk) begin
      if (cmd.blend_mul) begin
        num[k] <= NUM_W'(a_ch) * NUM_W'(wlo) + NUM_W'(b_ch) * NUM_W'(dpos)
                  + NUM_W'(span >> 1);
        q[k]   <= '0;
      end else if (cmd.bdiv_step) begin
        if (num[k] >= dvs) begin
          num[k] <= num[k] - dvs;
          q[k]   <= {q[k][CHW-2:0], 1'b1};
        end else begin
          q[k]   <= {q[k][CHW-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  logic [CLW-1:0] res;

  always_comb begin
    unique case (cmd.res_sel)
      lgce_pkg::RES_ZERO:  res = '0;
      lgce_pkg::RES_FIRST: res = first_colour;
      lgce_pkg::RES_LAST:  res = last_colour;
      lgce_pkg::RES_BLACK: res = lgce_pkg::OPAQUE_BLACK;
      default:             res = {q[0], q[1], q[2], q[3]};
    endcase
  end

  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_colour <= res;
    end
  end

  // a loaded result is always offered next cycle
  a_out_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not offered");

  // the bracket is never empty when interpolation starts
  a_span_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.blend_mul |-> (hi > SPAN_W'(lo)) && (SPAN_W'(t16) >= SPAN_W'(lo)))
    else $error("empty or misplaced bracket");

endmodule
